>>> src/irgbt_pkg.sv
package irgbt_pkg;

	// field widths
	localparam int GYRO_W  = 18;
	localparam int ACCEL_W = 17;
	localparam int DT_W    = 16;
	localparam int TIME_W  = 23;

	// bias accumulator: integer part of a gyro reading plus fraction bits
	localparam int BIAS_FRACTION_BITS = 16;
	localparam int ACC_W      = GYRO_W + BIAS_FRACTION_BITS;
	localparam int GAIN_SHIFT = 16;

	// squared norms and limits
	localparam int G2_W  = 2 * GYRO_W;
	localparam int A2_W  = 2 * ACCEL_W;
	localparam int LIM_W = 17;
	localparam int DEV_W = 13;
	localparam int HI_W  = DEV_W + 1;

	localparam logic [DEV_W-1:0]  ONE_G    = DEV_W'(4096);
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_GYRO_REST_LIMIT = 3'd0,
		REG_ACCEL_DEV_LIMIT = 3'd1,
		REG_REST_MIN_TIME   = 3'd2,
		REG_BIAS_GAIN       = 3'd3,
		REG_BIAS_LIMIT      = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [LIM_W-1:0]  gyro_rest_limit;
		logic [DEV_W-1:0]  accel_dev_limit;
		logic [TIME_W-1:0] rest_min_time;
		logic [16:0]       bias_gain;
		logic [16:0]       bias_limit;
	} cfg_t;

endpackage

>>> src/irgbt_if.sv
interface irgbt_imu_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [irgbt_pkg::GYRO_W-1:0]   gyro_x;
	logic signed [irgbt_pkg::GYRO_W-1:0]   gyro_y;
	logic signed [irgbt_pkg::GYRO_W-1:0]   gyro_z;
	logic signed [irgbt_pkg::ACCEL_W-1:0]  accel_x;
	logic signed [irgbt_pkg::ACCEL_W-1:0]  accel_y;
	logic signed [irgbt_pkg::ACCEL_W-1:0]  accel_z;
	logic        [irgbt_pkg::DT_W-1:0]     dt_us;

	modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, dt_us,
		input ready);
	modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, dt_us,
		output ready);
endinterface

interface irgbt_est_if;
	logic                                valid;
	logic                                ready;
	logic                                at_rest;
	logic signed [irgbt_pkg::GYRO_W-1:0] bias_x;
	logic signed [irgbt_pkg::GYRO_W-1:0] bias_y;
	logic signed [irgbt_pkg::GYRO_W-1:0] bias_z;

	modport source (output valid, at_rest, bias_x, bias_y, bias_z, input ready);
	modport sink (input valid, at_rest, bias_x, bias_y, bias_z, output ready);
endinterface

>>> src/irgbt_regs.sv
module irgbt_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [irgbt_pkg::ADDR_W-1:0]   paddr,
	input  logic [irgbt_pkg::DATA_W-1:0]   pwdata,
	output logic [irgbt_pkg::DATA_W-1:0]   prdata,
	output logic                           pready,
	output irgbt_pkg::cfg_t                cfg
);

	irgbt_pkg::cfg_t     cfg_q;
	irgbt_pkg::reg_idx_t idx;
	logic                wr;

	assign pready = 1'b1;
	assign idx    = irgbt_pkg::reg_idx_t'(paddr[irgbt_pkg::ADDR_W-1:2]);
	assign wr     = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gyro_rest_limit <= irgbt_pkg::LIM_W'(96);
			cfg_q.accel_dev_limit <= irgbt_pkg::DEV_W'(614);
			cfg_q.rest_min_time   <= irgbt_pkg::TIME_W'(2000000);
			cfg_q.bias_gain       <= 17'(655);
			cfg_q.bias_limit      <= 17'(192);
		end else if (wr) begin
			case (idx)
				irgbt_pkg::REG_GYRO_REST_LIMIT:
					cfg_q.gyro_rest_limit <= pwdata[irgbt_pkg::LIM_W-1:0];
				irgbt_pkg::REG_ACCEL_DEV_LIMIT:
					cfg_q.accel_dev_limit <= pwdata[irgbt_pkg::DEV_W-1:0];
				irgbt_pkg::REG_REST_MIN_TIME:
					cfg_q.rest_min_time <= pwdata[irgbt_pkg::TIME_W-1:0];
				irgbt_pkg::REG_BIAS_GAIN:   cfg_q.bias_gain <= pwdata[16:0];
				irgbt_pkg::REG_BIAS_LIMIT:  cfg_q.bias_limit <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// read mux, unmapped addresses read zero
	always_comb begin
		case (idx)
			irgbt_pkg::REG_GYRO_REST_LIMIT:
				prdata = irgbt_pkg::DATA_W'(cfg_q.gyro_rest_limit);
			irgbt_pkg::REG_ACCEL_DEV_LIMIT:
				prdata = irgbt_pkg::DATA_W'(cfg_q.accel_dev_limit);
			irgbt_pkg::REG_REST_MIN_TIME:
				prdata = irgbt_pkg::DATA_W'(cfg_q.rest_min_time);
			irgbt_pkg::REG_BIAS_GAIN:   prdata = irgbt_pkg::DATA_W'(cfg_q.bias_gain);
			irgbt_pkg::REG_BIAS_LIMIT:  prdata = irgbt_pkg::DATA_W'(cfg_q.bias_limit);
			default:                    prdata = '0;
		endcase
	end

endmodule

>>> src/irgbt_axis.sv
module irgbt_axis (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                upd,
	input  logic signed [irgbt_pkg::GYRO_W-1:0] rate,
	input  logic [16:0]                         gain,
	input  logic [16:0]                         clip,
	output logic signed [irgbt_pkg::GYRO_W-1:0] bias_nxt
);

	localparam int F    = irgbt_pkg::BIAS_FRACTION_BITS;
	localparam int AW   = irgbt_pkg::ACC_W;
	localparam int D_W  = AW + 1;
	localparam int P_W  = D_W + 18;
	localparam int SH_W = P_W - irgbt_pkg::GAIN_SHIFT;
	localparam int V_W  = SH_W + 1;

	logic signed [AW-1:0]   acc_q;
	logic signed [AW-1:0]   acc_nxt;
	logic signed [D_W-1:0]  diff;
	logic signed [P_W-1:0]  prod;
	logic signed [SH_W-1:0] delta;
	logic signed [V_W-1:0]  sum_v;
	logic signed [V_W-1:0]  lim_v;

	// move toward the reading by the gain, floor of the scaled product
	always_comb begin
		diff  = D_W'($signed({rate, {F{1'b0}}})) - D_W'(acc_q);
		prod  = P_W'(diff) * P_W'($signed({1'b0, gain}));
		delta = $signed(prod[P_W-1:irgbt_pkg::GAIN_SHIFT]);
		sum_v = V_W'(acc_q) + V_W'(delta);
		lim_v = V_W'($signed({1'b0, clip, {F{1'b0}}}));
	end

	// clip to plus or minus the limit
	always_comb begin
		priority if (sum_v > lim_v) begin
			acc_nxt = AW'(lim_v);
		end else if (sum_v < -lim_v) begin
			acc_nxt = AW'(-lim_v);
		end else begin
			acc_nxt = AW'(sum_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (upd) begin
			acc_q <= acc_nxt;
		end
	end

	// reported bias is the integer part of the updated accumulator
	assign bias_nxt = upd ? acc_nxt[AW-1:F] : acc_q[AW-1:F];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(acc_q))
		else $error("bias changed without a rest beat");

	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> (V_W'(acc_q) <= $past(lim_v)) && (V_W'(acc_q) >= -$past(lim_v)))
		else $error("bias outside clip range after update");

	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && gain == '0 && V_W'(acc_q) <= lim_v && V_W'(acc_q) >= -lim_v)
		|=> $stable(acc_q))
		else $error("zero gain moved bias");

endmodule

>>> src/imu_rest_gyro_bias_tracker.sv
// pipeline: a sample beat passes the stage 1, stage 2 and stage 3 registers to its result beat
// throughput: one sample per cycle while est.ready stays high; the rest timer and bias accumulators
// close their update loop on the second stage's data
// reset: arst_n clears the pipeline, rest timer and biases to zero and loads
// the register defaults; no clearing pass is needed
module imu_rest_gyro_bias_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	irgbt_imu_if.sink                      imu,
	irgbt_est_if.source                    est,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [irgbt_pkg::ADDR_W-1:0]   paddr,
	input  logic [irgbt_pkg::DATA_W-1:0]   pwdata,
	output logic [irgbt_pkg::DATA_W-1:0]   prdata,
	output logic                           pready
);

	localparam int GW  = irgbt_pkg::GYRO_W;
	localparam int AW  = irgbt_pkg::ACCEL_W;
	localparam int TW  = irgbt_pkg::TIME_W;
	localparam int G2W = irgbt_pkg::G2_W;
	localparam int A2W = irgbt_pkg::A2_W;
	localparam int HW  = irgbt_pkg::HI_W;
	localparam int DW  = irgbt_pkg::DEV_W;

	irgbt_pkg::cfg_t cfg;

	// stage valids and ready chain
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic step;

	// stage 1 sample
	logic signed [GW-1:0]           gyro_s1 [3];
	logic signed [AW-1:0]           accel_s1 [3];
	logic [irgbt_pkg::DT_W-1:0]     dt_s1;

	// stage 2 still flag and carried data
	logic                           still_s2;
	logic signed [GW-1:0]           gyro_s2 [3];
	logic [irgbt_pkg::DT_W-1:0]     dt_s2;

	// stage 3 result
	logic                           at_rest_s3;
	logic signed [GW-1:0]           bias_s3 [3];
	logic signed [GW-1:0]           bias_nxt [3];

	logic [TW-1:0]                  rest_time_q;

	// stillness detection
	logic [G2W-1:0]                 g2;
	logic [A2W-1:0]                 a2;
	logic [2*irgbt_pkg::LIM_W-1:0]  lim2;
	logic [HW-1:0]                  hi;
	logic [2*HW-1:0]                hi2;
	logic [DW-1:0]                  lo;
	logic [2*DW-1:0]                lo2;
	logic                           lo_used;
	logic                           gyro_calm, accel_calm;

	// rest timer
	logic [TW:0]                    time_sum;
	logic [TW-1:0]                  time_nxt;
	logic                           rest_c;

	irgbt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign rdy_s3    = !v_s3 || est.ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign imu.ready = rdy_s1;
	assign step      = v_s2 && rdy_s3;

	// stage 1: sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= imu.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (imu.valid && rdy_s1) begin
			gyro_s1[0]  <= imu.gyro_x;
			gyro_s1[1]  <= imu.gyro_y;
			gyro_s1[2]  <= imu.gyro_z;
			accel_s1[0] <= imu.accel_x;
			accel_s1[1] <= imu.accel_y;
			accel_s1[2] <= imu.accel_z;
			dt_s1       <= imu.dt_us;
		end
	end

	// squared norms against squared limits
	always_comb begin
		g2 = G2W'($unsigned(G2W'(gyro_s1[0]) * G2W'(gyro_s1[0])))
			+ G2W'($unsigned(G2W'(gyro_s1[1]) * G2W'(gyro_s1[1])))
			+ G2W'($unsigned(G2W'(gyro_s1[2]) * G2W'(gyro_s1[2])));
		a2 = A2W'($unsigned(A2W'(accel_s1[0]) * A2W'(accel_s1[0])))
			+ A2W'($unsigned(A2W'(accel_s1[1]) * A2W'(accel_s1[1])))
			+ A2W'($unsigned(A2W'(accel_s1[2]) * A2W'(accel_s1[2])));
		lim2    = (2*irgbt_pkg::LIM_W)'(cfg.gyro_rest_limit)
			* (2*irgbt_pkg::LIM_W)'(cfg.gyro_rest_limit);
		hi      = HW'(irgbt_pkg::ONE_G) + HW'(cfg.accel_dev_limit);
		hi2     = (2*HW)'(hi) * (2*HW)'(hi);
		lo_used = cfg.accel_dev_limit <= irgbt_pkg::ONE_G;
		lo      = irgbt_pkg::ONE_G - cfg.accel_dev_limit;
		lo2     = (2*DW)'(lo) * (2*DW)'(lo);

		gyro_calm  = g2 < G2W'(lim2);
		// lower bound only applies while one g minus the deviation is not negative
		accel_calm = (a2 < A2W'(hi2)) && (!lo_used || (a2 > A2W'(lo2)));
	end

	// stage 2: still flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			still_s2 <= gyro_calm && accel_calm;
			gyro_s2  <= gyro_s1;
			dt_s2    <= dt_s1;
		end
	end

	// saturating rest timer, cleared by any moving sample
	always_comb begin
		time_sum = (TW+1)'(rest_time_q) + (TW+1)'(dt_s2);
		if (!still_s2) begin
			time_nxt = '0;
		end else if (time_sum > (TW+1)'(irgbt_pkg::TIME_MAX)) begin
			time_nxt = irgbt_pkg::TIME_MAX;
		end else begin
			time_nxt = time_sum[TW-1:0];
		end
		rest_c = still_s2 && (time_nxt >= cfg.rest_min_time);
	end

	// per-axis bias trackers
	for (genvar i = 0; i < 3; i++) begin : g_axis
		irgbt_axis u_axis (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (step && rest_c),
			.rate     (gyro_s2[i]),
			.gain     (cfg.bias_gain),
			.clip     (cfg.bias_limit),
			.bias_nxt (bias_nxt[i])
		);
	end

	// stage 3: result register and rest timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			rest_time_q <= '0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (step) begin
				rest_time_q <= time_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			at_rest_s3 <= rest_c;
			bias_s3    <= bias_nxt;
		end
	end

	assign est.valid   = v_s3;
	assign est.at_rest = at_rest_s3;
	assign est.bias_x  = bias_s3[0];
	assign est.bias_y  = bias_s3[1];
	assign est.bias_z  = bias_s3[2];

	a_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !still_s2) |=> (rest_time_q == '0))
		else $error("rest timer not cleared by moving sample");

	a_timer_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(rest_time_q))
		else $error("rest timer changed without a beat");

	a_rest_time: assert property (@(posedge clk) disable iff (!arst_n)
		(step && rest_c) |=> (rest_time_q >= $past(cfg.rest_min_time)))
		else $error("rest declared before minimum time");

endmodule

>>> test/imu_rest_gyro_bias_tracker_tb.sv
module imu_rest_gyro_bias_tracker_tb;

	import irgbt_pkg::*;

	localparam int STALL_MAX  = 11;
	localparam int QUIET_MAX  = 1000;
	localparam int REPORT_MAX = 30;

	typedef struct packed {
		logic [2:0][GYRO_W-1:0]  gyro;
		logic [2:0][ACCEL_W-1:0] accel;
		logic [DT_W-1:0]         dt;
	} sample_t;

	typedef struct packed {
		logic                   at_rest;
		logic [2:0][GYRO_W-1:0] bias;
	} estimate_t;

	// ways of landing a sample right on the edge of a stillness band
	typedef enum int {
		EDGE_GYRO_AT,
		EDGE_GYRO_BELOW,
		EDGE_GYRO_NEG,
		EDGE_ACCEL_HI,
		EDGE_ACCEL_HI_IN,
		EDGE_ACCEL_LO,
		EDGE_ACCEL_LO_IN
	} edge_kind_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	irgbt_imu_if imu_bus ();
	irgbt_est_if est_bus ();

	imu_rest_gyro_bias_tracker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.imu     (imu_bus),
		.est     (est_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the register file and the tracker state
	cfg_t       cfg_shadow;
	longint     rest_timer_us;
	longint     bias_acc [3];
	estimate_t  pending_estimates [$];

	bit steady_flow;
	int mismatches;
	int samples_sent;
	int estimates_checked;
	int rest_estimates;
	int timer_full_hits;
	int settings_used;
	int quiet_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch: %s got %0d want %0d (estimate %0d)", what, got, want,
				estimates_checked);
	endtask

	function automatic int rand_span(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo, 0));
	endfunction

	// stillness test, rest timer and bias tracking for one sample
	function automatic estimate_t predict_estimate(input sample_t s);
		longint    g [3];
		longint    a [3];
		longint    g2, a2, lim, hi, lo, clip, d, v, gain;
		bit        still, rest;
		estimate_t e;
		g2 = 0;
		a2 = 0;
		for (int k = 0; k < 3; k++) begin
			g[k] = longint'($signed(s.gyro[k]));
			a[k] = longint'($signed(s.accel[k]));
			g2 += g[k] * g[k];
			a2 += a[k] * a[k];
		end
		lim = longint'(cfg_shadow.gyro_rest_limit);
		hi  = longint'(ONE_G) + longint'(cfg_shadow.accel_dev_limit);
		lo  = longint'(ONE_G) - longint'(cfg_shadow.accel_dev_limit);
		still = (g2 < lim * lim) && (a2 < hi * hi) && (lo < 0 || a2 > lo * lo);

		// saturating rest timer
		if (still) begin
			rest_timer_us += longint'(s.dt);
			if (rest_timer_us >= longint'(TIME_MAX)) begin
				rest_timer_us = longint'(TIME_MAX);
				timer_full_hits++;
			end
		end else begin
			rest_timer_us = 0;
		end
		rest = still && rest_timer_us >= longint'(cfg_shadow.rest_min_time);

		// pull each bias toward the gyro and clip it
		if (rest) begin
			clip = longint'(cfg_shadow.bias_limit) <<< BIAS_FRACTION_BITS;
			gain = longint'(cfg_shadow.bias_gain);
			for (int k = 0; k < 3; k++) begin
				d = (g[k] <<< BIAS_FRACTION_BITS) - bias_acc[k];
				v = bias_acc[k] + ((d * gain) >>> GAIN_SHIFT);
				if (v > clip)
					v = clip;
				else if (v < -clip)
					v = -clip;
				bias_acc[k] = v;
			end
		end

		e.at_rest = rest;
		for (int k = 0; k < 3; k++)
			e.bias[k] = GYRO_W'(bias_acc[k] >>> BIAS_FRACTION_BITS);
		return e;
	endfunction

	function automatic sample_t mk(input int gx, input int gy, input int gz,
		input int ax, input int ay, input int az, input int dt);
		sample_t s;
		s.gyro[0]  = GYRO_W'(gx);
		s.gyro[1]  = GYRO_W'(gy);
		s.gyro[2]  = GYRO_W'(gz);
		s.accel[0] = ACCEL_W'(ax);
		s.accel[1] = ACCEL_W'(ay);
		s.accel[2] = ACCEL_W'(az);
		s.dt       = DT_W'(dt);
		return s;
	endfunction

	// still samples at the given percentage, the rest split between band edges and full-range noise
	function automatic sample_t make_sample(input int still_pct, input bit long_dt);
		sample_t    s;
		int         lim, dev, half, span, side, ax, sgn;
		edge_kind_t kind;
		lim = int'(cfg_shadow.gyro_rest_limit);
		dev = int'(cfg_shadow.accel_dev_limit);
		for (int k = 0; k < 3; k++) begin
			s.gyro[k]  = GYRO_W'($urandom);
			s.accel[k] = ACCEL_W'($urandom);
		end
		s.dt = DT_W'($urandom);
		ax   = rand_span(0, 2);
		sgn  = (rand_span(0, 1) == 1) ? 1 : -1;
		case (rand_span(0, 99) < still_pct ? 0 : rand_span(1, 2))
			0: begin
				half = lim / 2;
				span = (dev / 2 > 4000) ? 4000 : dev / 2;
				side = (dev / 4 > 256) ? 256 : dev / 4;
				for (int k = 0; k < 3; k++) begin
					s.gyro[k]  = GYRO_W'(rand_span(-half, half));
					s.accel[k] = ACCEL_W'(rand_span(-side, side));
				end
				s.accel[ax] = ACCEL_W'(sgn * (int'(ONE_G) + rand_span(-span, span)));
			end
			1: begin
				s.gyro  = '0;
				s.accel = '0;
				s.accel[ax] = ACCEL_W'(sgn * int'(ONE_G));
				kind = edge_kind_t'(rand_span(0, 6));
				case (kind)
					EDGE_GYRO_AT:     s.gyro[ax] = GYRO_W'(lim);
					EDGE_GYRO_BELOW:  s.gyro[ax] = GYRO_W'(lim > 0 ? lim - 1 : 0);
					EDGE_GYRO_NEG:    s.gyro[ax] = GYRO_W'(-lim);
					EDGE_ACCEL_HI:    s.accel[ax] = ACCEL_W'(sgn * (int'(ONE_G) + dev));
					EDGE_ACCEL_HI_IN: s.accel[ax] = ACCEL_W'(sgn * (int'(ONE_G) + dev - 1));
					EDGE_ACCEL_LO:    s.accel[ax] = ACCEL_W'(sgn * (int'(ONE_G) - dev));
					EDGE_ACCEL_LO_IN: s.accel[ax] = ACCEL_W'(sgn * (int'(ONE_G) - dev + 1));
					default: ;
				endcase
			end
			default: ;
		endcase
		if (long_dt)
			s.dt = (rand_span(0, 9) == 0) ? DT_W'($urandom) : '1;
		else if (rand_span(0, 15) == 0)
			s.dt = '0;
		return s;
	endfunction

	// drive one sample beat and record its expected estimate on acceptance
	task automatic send_sample(input sample_t s);
		int gap;
		gap = steady_flow ? 0 : rand_span(0, STALL_MAX);
		@(negedge clk);
		if (gap > 0) begin
			imu_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		imu_bus.gyro_x  = s.gyro[0];
		imu_bus.gyro_y  = s.gyro[1];
		imu_bus.gyro_z  = s.gyro[2];
		imu_bus.accel_x = s.accel[0];
		imu_bus.accel_y = s.accel[1];
		imu_bus.accel_z = s.accel[2];
		imu_bus.dt_us   = s.dt;
		imu_bus.valid   = 1'b1;
		do @(posedge clk); while (!imu_bus.ready);
		pending_estimates.push_back(predict_estimate(s));
		samples_sent++;
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		imu_bus.valid = 1'b0;
		while (pending_estimates.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_W'(int'(idx) * 4);
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_GYRO_REST_LIMIT: cfg_shadow.gyro_rest_limit = value[LIM_W-1:0];
			REG_ACCEL_DEV_LIMIT: cfg_shadow.accel_dev_limit = value[DEV_W-1:0];
			REG_REST_MIN_TIME:   cfg_shadow.rest_min_time   = value[TIME_W-1:0];
			REG_BIAS_GAIN:       cfg_shadow.bias_gain       = value[16:0];
			REG_BIAS_LIMIT:      cfg_shadow.bias_limit      = value[16:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic reg_read(input reg_idx_t idx, output logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = ADDR_W'(int'(idx) * 4);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// new register setting, only once the pipeline is empty
	task automatic set_config(input int lim, input int dev, input int min_us, input int gain,
		input int clip);
		drain_pipeline();
		reg_write(REG_GYRO_REST_LIMIT, DATA_W'(lim));
		reg_write(REG_ACCEL_DEV_LIMIT, DATA_W'(dev));
		reg_write(REG_REST_MIN_TIME, DATA_W'(min_us));
		reg_write(REG_BIAS_GAIN, DATA_W'(gain));
		reg_write(REG_BIAS_LIMIT, DATA_W'(clip));
		settings_used++;
	endtask

	task automatic test_register_defaults();
		logic [DATA_W-1:0] got;
		reg_read(REG_GYRO_REST_LIMIT, got);
		if (got !== DATA_W'(96)) report_mismatch("gyro_rest_limit reset", got, 96);
		reg_read(REG_ACCEL_DEV_LIMIT, got);
		if (got !== DATA_W'(614)) report_mismatch("accel_dev_limit reset", got, 614);
		reg_read(REG_REST_MIN_TIME, got);
		if (got !== DATA_W'(2000000)) report_mismatch("rest_min_time reset", got, 2000000);
		reg_read(REG_BIAS_GAIN, got);
		if (got !== DATA_W'(655)) report_mismatch("bias_gain reset", got, 655);
		reg_read(REG_BIAS_LIMIT, got);
		if (got !== DATA_W'(192)) report_mismatch("bias_limit reset", got, 192);
	endtask

	// field extremes and both sides of each band edge at the reset settings
	task automatic test_field_extremes();
		send_sample(mk(0, 0, 0, 0, 0, 0, 0));
		send_sample(mk(131071, 131071, 131071, 65535, 65535, 65535, 65535));
		send_sample(mk(-131072, -131072, -131072, -65536, -65536, -65536, 65535));
		send_sample(mk(0, 0, 0, 0, 0, 4096, 65535));
		send_sample(mk(95, 0, 0, 0, 0, -4096, 65535));
		send_sample(mk(0, 96, 0, 0, 4096, 0, 100));
		send_sample(mk(0, 0, 0, 4710, 0, 0, 1));
		send_sample(mk(0, 0, 0, 0, 4709, 0, 1));
		send_sample(mk(0, 0, 0, 0, 0, 3482, 1));
		send_sample(mk(0, 0, -55, 0, 0, 3483, 1));
	endtask

	// zero deviation never still; deviation above one g opens the low side, at one g a zero reading is not still
	task automatic test_accel_band_limits();
		set_config(96, 0, 0, 32768, 192);
		send_sample(mk(0, 0, 0, 0, 0, 4096, 10));
		set_config(96, 5000, 0, 32768, 192);
		send_sample(mk(40, -40, 20, 0, 0, 0, 10));
		set_config(96, 8191, 0, 32768, 192);
		send_sample(mk(10, 0, 0, 0, 0, 0, 10));
		send_sample(mk(0, 0, 0, 12000, 0, 0, 5));
		set_config(96, 4096, 0, 32768, 192);
		send_sample(mk(0, 0, 0, 0, 0, 0, 10));
		send_sample(mk(0, 0, 0, 0, 8191, 0, 3));
	endtask

	// zero minimum rest time: the first still sample is already at rest
	task automatic test_zero_rest_time();
		set_config(96, 614, 0, 65536, 192);
		send_sample(mk(50, -60, 30, 0, 0, 4096, 0));
		send_sample(mk(-70, 20, -10, 0, 0, 4096, 0));
		set_config(96, 614, 0, 65536, 20);
		send_sample(mk(60, -60, 5, 0, 0, 4096, 0));
	endtask

	// gain beyond unity overshoots and then hits the clip; zero gain holds
	task automatic test_gain_overshoot();
		set_config(131071, 614, 0, 131071, 131071);
		send_sample(mk(1000, -2000, 500, 0, 4096, 0, 7));
		send_sample(mk(1000, -2000, 500, 0, 4096, 0, 7));
		send_sample(mk(70000, -70000, 0, 0, 0, 4096, 7));
		set_config(131071, 614, 0, 0, 131071);
		send_sample(mk(-5000, 5000, 1, 0, 0, 4096, 7));
	endtask

	// a lowered clip leaves the bias alone until the next rest sample
	task automatic test_clip_lowered();
		set_config(96, 614, 0, 65536, 131071);
		send_sample(mk(80, -80, 40, 0, 0, 4096, 1));
		send_sample(mk(80, -80, 40, 0, 0, 0, 1));
		set_config(96, 614, 0, 65536, 10);
		send_sample(mk(0, 0, 0, 0, 0, 0, 1));
		send_sample(mk(80, -80, 40, 0, 0, 4096, 1));
	endtask

	task automatic run_random_phase(input int count, input int still_pct, input bit long_dt);
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0)
				steady_flow = (rand_span(0, 3) == 0);
			send_sample(make_sample(still_pct, long_dt));
		end
		steady_flow = 1'b0;
	endtask

	task automatic test_random_mix();
		set_config(rand_span(50, 2000), rand_span(100, 1500), rand_span(0, 100000),
			rand_span(0, 65536), rand_span(0, 131071));
		run_random_phase(150, 85, 1'b0);
		set_config(131071, 4096, 0, 65536, 131071);
		run_random_phase(80, 80, 1'b0);
		set_config(0, 0, 0, 0, 0);
		run_random_phase(40, 50, 1'b0);
		// long still runs to drive the rest timer into saturation
		set_config(2000, 800, 8388607, 4000, 500);
		run_random_phase(150, 97, 1'b1);
		set_config(rand_span(0, 131071), rand_span(0, 8191), rand_span(0, 400000),
			rand_span(0, 131071), rand_span(0, 131071));
		run_random_phase(150, 85, 1'b0);
		set_config(96, 614, 2000000, 655, 192);
		run_random_phase(80, 95, 1'b1);
	endtask

	// result side: random stall before each estimate beat
	initial begin
		int stall;
		est_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = steady_flow ? 0 : rand_span(0, STALL_MAX);
			if (stall > 0) begin
				est_bus.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			est_bus.ready = 1'b1;
			do @(posedge clk); while (!est_bus.valid);
		end
	end

	// compare each estimate beat with the oldest prediction
	always @(posedge clk) begin
		estimate_t want;
		if (arst_n && est_bus.valid && est_bus.ready) begin
			if (pending_estimates.size() == 0) begin
				report_mismatch("estimate with none pending, bias_x", $signed(est_bus.bias_x), 0);
			end else begin
				want = pending_estimates.pop_front();
				if (est_bus.at_rest !== want.at_rest)
					report_mismatch("at_rest", est_bus.at_rest, want.at_rest);
				if (est_bus.bias_x !== want.bias[0])
					report_mismatch("bias_x", $signed(est_bus.bias_x), $signed(want.bias[0]));
				if (est_bus.bias_y !== want.bias[1])
					report_mismatch("bias_y", $signed(est_bus.bias_y), $signed(want.bias[1]));
				if (est_bus.bias_z !== want.bias[2])
					report_mismatch("bias_z", $signed(est_bus.bias_z), $signed(want.bias[2]));
				if (want.at_rest)
					rest_estimates++;
			end
			estimates_checked++;
		end
	end

	// watchdog on cycles without any beat or register access
	always @(posedge clk) begin
		if ((imu_bus.valid && imu_bus.ready) || (est_bus.valid && est_bus.ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("timeout with %0d estimates pending", pending_estimates.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		imu_bus.valid   = 1'b0;
		imu_bus.gyro_x  = '0;
		imu_bus.gyro_y  = '0;
		imu_bus.gyro_z  = '0;
		imu_bus.accel_x = '0;
		imu_bus.accel_y = '0;
		imu_bus.accel_z = '0;
		imu_bus.dt_us   = '0;
		steady_flow     = 1'b0;
		mismatches      = 0;
		quiet_cycles    = 0;
		settings_used   = 1;
		cfg_shadow.gyro_rest_limit = LIM_W'(96);
		cfg_shadow.accel_dev_limit = DEV_W'(614);
		cfg_shadow.rest_min_time   = TIME_W'(2000000);
		cfg_shadow.bias_gain       = 17'd655;
		cfg_shadow.bias_limit      = 17'd192;
		rest_timer_us = 0;
		for (int k = 0; k < 3; k++)
			bias_acc[k] = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_defaults();
		test_field_extremes();
		test_accel_band_limits();
		test_zero_rest_time();
		test_gain_overshoot();
		test_clip_lowered();
		test_random_mix();

		drain_pipeline();
		repeat (8) @(posedge clk);
		if (pending_estimates.size() != 0)
			report_mismatch("estimates never delivered", 0, pending_estimates.size());

		$display("ran %0d imu samples over %0d register settings, %0d estimates compared",
			samples_sent, settings_used, estimates_checked);
		$display("%0d estimates at rest, %0d samples with the rest timer full, %0d mismatches",
			rest_estimates, timer_full_hits, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
